>>> src/tess_pkg.sv
package tess_pkg;

  localparam int COORD_W   = 16;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_AW    = $clog2(JOB_DEPTH);

  typedef enum logic [1:0] {
    MODE_RECT    = 2'd0,
    MODE_OUTLINE = 2'd1,
    MODE_LINE    = 2'd2,
    MODE_CIRCLE  = 2'd3
  } mode_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [14:0]        norm_t;
  typedef logic signed [19:0]        wide_t;

  typedef struct packed {
    mode_t       mode;
    coord_t      px;
    coord_t      py;
    coord_t      ex;
    coord_t      ey;
    norm_t       nx;
    norm_t       ny;
    logic [14:0] radius;
    logic [11:0] thick;
    logic [3:0]  mask;
    logic [31:0] color;
  } job_t;

  function automatic logic [14:0] quarter_sine(input logic [5:0] r);
    logic [14:0] v;
    case (r)
      6'd0:  v = 15'd0;
      6'd1:  v = 15'd804;
      6'd2:  v = 15'd1606;
      6'd3:  v = 15'd2404;
      6'd4:  v = 15'd3196;
      6'd5:  v = 15'd3981;
      6'd6:  v = 15'd4756;
      6'd7:  v = 15'd5520;
      6'd8:  v = 15'd6270;
      6'd9:  v = 15'd7005;
      6'd10: v = 15'd7723;
      6'd11: v = 15'd8423;
      6'd12: v = 15'd9102;
      6'd13: v = 15'd9760;
      6'd14: v = 15'd10394;
      6'd15: v = 15'd11003;
      6'd16: v = 15'd11585;
      6'd17: v = 15'd12140;
      6'd18: v = 15'd12665;
      6'd19: v = 15'd13160;
      6'd20: v = 15'd13623;
      6'd21: v = 15'd14053;
      6'd22: v = 15'd14449;
      6'd23: v = 15'd14811;
      6'd24: v = 15'd15137;
      6'd25: v = 15'd15426;
      6'd26: v = 15'd15679;
      6'd27: v = 15'd15893;
      6'd28: v = 15'd16069;
      6'd29: v = 15'd16207;
      6'd30: v = 15'd16305;
      6'd31: v = 15'd16364;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] table_sin(input logic [6:0] k);
    logic [5:0]  r;
    logic [5:0]  rr;
    logic [15:0] a;
    logic [15:0] b;
    r  = {1'b0, k[4:0]};
    rr = 6'd32 - r;
    a  = {1'b0, quarter_sine(r)};
    b  = {1'b0, quarter_sine(rr)};
    case (k[6:5])
      2'd0:    return $signed(a);
      2'd1:    return $signed(b);
      2'd2:    return -$signed(a);
      default: return -$signed(b);
    endcase
  endfunction

  // rounded trig * radius / 2^14, halves away from zero
  function automatic logic signed [17:0] scale_round(input logic signed [15:0] trig,
                                                     input logic [14:0] radius);
    logic signed [31:0] p;
    logic [31:0]        m;
    logic [31:0]        q;
    p = 32'(trig) * $signed({17'd0, radius});
    m = p[31] ? 32'(-p) : 32'(p);
    q = (m + 32'd8192) >> 14;
    return p[31] ? -$signed(q[17:0]) : $signed(q[17:0]);
  endfunction

  function automatic coord_t sat16(input wide_t v);
    if (v > 20'sd32767) return 16'sh7fff;
    else if (v < -20'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

endpackage

>>> src/primitive_triangle_tessellator_core.sv
// Turns one draw command per item into flat-colored triangles, one triangle per output
// item with tlast on the final one. A filled rect gives 2 triangles, an outline up to 8,
// a line 2 and a circle CIRCLE_SEGMENTS; commands that cover nothing give no output.
// The back end emits one triangle per cycle while the output is not stalled, from a 4-deep
// command queue, and rects can be taken every cycle while the queue has room. A line is
// worked in the front end after it is taken (squared length, 25-step square root, divider
// setup, two 14-step divisions for the normal, queue write) and the front takes no new
// command meanwhile. Coordinates are signed Q12.4, saturated.
module primitive_triangle_tessellator_core #(
  parameter int CIRCLE_SEGMENTS = 32,
  parameter int FRACTION_BITS   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, extent_x, extent_y, radius, thickness, color_red, color_green,
  // color_blue, color_alpha, zero fill
  input  logic [127:0] s_tdata,
  // mode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, out_red, out_green, out_blue, out_alpha
  output logic [127:0] m_tdata,
  output logic         m_tlast
);
  import tess_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  job_valid;
  job_t  push_job;
  job_t  job;

  tess_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_px    (s_tdata[15:0]),
    .in_py    (s_tdata[31:16]),
    .in_ex    (s_tdata[47:32]),
    .in_ey    (s_tdata[63:48]),
    .in_radius(s_tdata[78:64]),
    .in_thick (s_tdata[90:79]),
    .in_color (s_tdata[122:91]),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  tess_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (push_job),
    .full   (full),
    .pop    (pop),
    .dvalid (job_valid),
    .dout   (job)
  );

  tess_back #(.CIRCLE_SEGMENTS(CIRCLE_SEGMENTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> src/tess_fifo.sv
module tess_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tess_pkg::job_t  din,
  output logic            full,
  input  logic            pop,
  output logic            dvalid,
  output tess_pkg::job_t  dout
);
  import tess_pkg::*;

  job_t                   mem [JOB_DEPTH];
  logic [JOB_AW-1:0]      wp;
  logic [JOB_AW-1:0]      rp;
  logic [JOB_AW:0]        cnt;
  logic [JOB_AW:0]        cnt_next;
  logic                   load;

  assign full = (cnt == (JOB_AW+1)'(JOB_DEPTH));
  assign load = (cnt != '0) && (!dvalid || pop);

  always_comb begin
    cnt_next = cnt;
    if (push) cnt_next = cnt_next + 1'b1;
    if (load) cnt_next = cnt_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
    if (load) dout <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      cnt    <= '0;
      dvalid <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (load) rp <= rp + 1'b1;
      cnt <= cnt_next;
      if (load) dvalid <= 1'b1;
      else if (pop) dvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    dvalid && !pop |=> dvalid && $stable(dout))
    else $error("queue head changed without pop");
`endif

endmodule

>>> src/tess_front.sv
module tess_front #(
  parameter int FRACTION_BITS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  tess_pkg::coord_t in_px,
  input  tess_pkg::coord_t in_py,
  input  tess_pkg::coord_t in_ex,
  input  tess_pkg::coord_t in_ey,
  input  logic [14:0]      in_radius,
  input  logic [11:0]      in_thick,
  input  logic [31:0]      in_color,
  output logic             push,
  output tess_pkg::job_t   push_job,
  input  logic             full
);
  import tess_pkg::*;

  localparam logic [11:0] ONE = 12'(1 << FRACTION_BITS);

  typedef enum logic [2:0] {S_TAKE, S_LEN, S_SQRT, S_DSET, S_DIVX, S_DIVY, S_PUSH} state_t;

  state_t             state;
  job_t               cmd;
  job_t               fast_job;
  logic               accept;
  logic               nonempty;
  logic [11:0]        t_in;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0]        dx_abs;
  logic [16:0]        dy_abs;
  logic [15:0]        adx;
  logic [15:0]        ady;
  logic               dx_pos;
  logic               dy_pos;
  logic [27:0]        pxt;
  logic [27:0]        pyt;
  logic [49:0]        rad;
  logic [27:0]        rem;
  logic [27:0]        rem_sh;
  logic [27:0]        trial;
  logic               sq_ge;
  logic [24:0]        root;
  logic [24:0]        root_next;
  logic [4:0]         cnt;
  logic [25:0]        den;
  logic [36:0]        num;
  logic [25:0]        drem;
  logic [13:0]        dlow;
  logic [26:0]        dsh;
  logic               d_ge;
  logic [13:0]        quo;
  logic [13:0]        quo_next;
  logic [32:0]        l2;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == S_TAKE) && !full;
  assign t_in = (in_thick < ONE) ? ONE : in_thick;
  assign dx = 17'(in_ex) - 17'(in_px);
  assign dy = 17'(in_ey) - 17'(in_py);
  assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
  assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);

  always_comb begin
    fast_job.mode   = mode_t'(in_mode);
    fast_job.px     = in_px;
    fast_job.py     = in_py;
    fast_job.ex     = in_ex;
    fast_job.ey     = in_ey;
    fast_job.nx     = '0;
    fast_job.ny     = '0;
    fast_job.radius = in_radius;
    fast_job.thick  = t_in;
    fast_job.color  = in_color;
    fast_job.mask   = {in_ey > 0, in_ey > 0, in_ex > 0, in_ex > 0};
    unique case (mode_t'(in_mode))
      MODE_RECT:    nonempty = (in_ex > 0) && (in_ey > 0);
      MODE_OUTLINE: nonempty = (in_ex > 0) || (in_ey > 0);
      MODE_LINE:    nonempty = (dx != 0) || (dy != 0);
      MODE_CIRCLE:  nonempty = (in_radius != '0);
      default:      nonempty = 1'b0;
    endcase
  end

  // square root, two bits of radicand a step
  assign rem_sh    = {rem[25:0], rad[49:48]};
  assign trial     = {1'b0, root, 2'b01};
  assign sq_ge     = rem_sh >= trial;
  assign root_next = {root[23:0], sq_ge};

  // divider, one quotient bit a step
  assign den      = {root, 1'b0};
  assign num      = {1'b0, (state == S_DSET) ? pxt : pyt, 8'd0} + 37'(root);
  assign dsh      = {drem, dlow[13]};
  assign d_ge     = dsh >= {1'b0, den};
  assign quo_next = {quo[12:0], d_ge};
  assign l2       = 33'(32'(adx) * 32'(adx)) + 33'(32'(ady) * 32'(ady));

  assign push     = (accept && (mode_t'(in_mode) != MODE_LINE) && nonempty) ||
                    ((state == S_PUSH) && !full);
  assign push_job = (state == S_PUSH) ? cmd : fast_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_TAKE: begin
          if (accept && (mode_t'(in_mode) == MODE_LINE) && nonempty) begin
            cmd    <= fast_job;
            adx    <= dx_abs[15:0];
            ady    <= dy_abs[15:0];
            dx_pos <= !dx[16] && (dx != 0);
            dy_pos <= !dy[16] && (dy != 0);
            state  <= S_LEN;
          end
        end
        S_LEN: begin
          rad   <= {1'b0, l2, 16'd0};
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          pxt   <= 28'(ady) * 28'(cmd.thick);
          pyt   <= 28'(adx) * 28'(cmd.thick);
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem  <= sq_ge ? 28'(rem_sh - trial) : rem_sh;
          root <= root_next;
          rad  <= {rad[47:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd24) state <= S_DSET;
        end
        S_DSET: begin
          drem  <= 26'(num[36:14]);
          dlow  <= num[13:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIVX;
        end
        S_DIVX, S_DIVY: begin
          if (cnt == 5'd13) begin
            cnt <= '0;
            if (state == S_DIVX) begin
              cmd.nx <= dy_pos ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
              drem   <= 26'(num[36:14]);
              dlow   <= num[13:0];
              quo    <= '0;
              state  <= S_DIVY;
            end else begin
              cmd.ny <= dx_pos ? $signed({1'b0, quo_next}) : -$signed({1'b0, quo_next});
              state  <= S_PUSH;
            end
          end else begin
            drem <= d_ge ? 26'(dsh - {1'b0, den}) : dsh[25:0];
            dlow <= {dlow[12:0], 1'b0};
            quo  <= quo_next;
            cnt  <= cnt + 1'b1;
          end
        end
        S_PUSH: begin
          if (!full) state <= S_TAKE;
        end
        default: state <= S_TAKE;
      endcase
    end
  end

endmodule

>>> src/tess_back.sv
module tess_back #(
  parameter int CIRCLE_SEGMENTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  tess_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [127:0]   out_data,
  output logic           out_last
);
  import tess_pkg::*;

  localparam int AW = $clog2(CIRCLE_SEGMENTS + 1);

  job_t          cur;
  logic          active;
  logic          half;
  logic [1:0]    ridx;
  logic [1:0]    ridx_nxt;
  logic [1:0]    ridx_first;
  logic [3:0]    higher;
  logic [AW-1:0] seg;
  logic [AW-1:0] seg_p1;
  logic [6:0]    ang [CIRCLE_SEGMENTS+1];
  logic          advance;
  logic          fire;
  logic          cur_last;
  wide_t         px, py, ex, ey, nx, ny, tk;
  wide_t         rx, ry, rw, rh;
  wide_t         ax, ay, bx, by, cx, cy;
  logic signed [17:0] c0x, c0y, c1x, c1y;

  for (genvar g = 0; g <= CIRCLE_SEGMENTS; g++) begin : g_ang
    assign ang[g] = 7'((g * 128) / CIRCLE_SEGMENTS);
  end

  assign seg_p1  = seg + 1'b1;
  assign advance = !out_valid || out_ready;
  assign fire    = active && advance;
  assign pop     = job_valid && (!active || (fire && cur_last));

  always_comb begin
    px = 20'(cur.px);
    py = 20'(cur.py);
    ex = 20'(cur.ex);
    ey = 20'(cur.ey);
    nx = 20'(cur.nx);
    ny = 20'(cur.ny);
    tk = $signed({8'd0, cur.thick});
    case (ridx)
      2'd0:    higher = {cur.mask[3:1], 1'b0};
      2'd1:    higher = {cur.mask[3:2], 2'b0};
      2'd2:    higher = {cur.mask[3], 3'b0};
      default: higher = 4'd0;
    endcase
    ridx_nxt = ridx;
    for (int j = 3; j >= 0; j--) begin
      if (higher[j]) ridx_nxt = 2'(j);
    end
    ridx_first = 2'd0;
    for (int j = 3; j >= 0; j--) begin
      if (job.mask[j]) ridx_first = 2'(j);
    end
    rx = px;
    ry = py;
    rw = ex;
    rh = ey;
    if (cur.mode == MODE_OUTLINE) begin
      case (ridx)
        2'd0: rh = tk;
        2'd1: begin
          ry = py + ey - tk;
          rh = tk;
        end
        2'd2: rw = tk;
        default: begin
          rx = px + ex - tk;
          rw = tk;
        end
      endcase
    end
    c0x = scale_round(table_sin(7'(ang[seg] + 7'd32)), cur.radius);
    c0y = scale_round(table_sin(ang[seg]), cur.radius);
    c1x = scale_round(table_sin(7'(ang[seg_p1] + 7'd32)), cur.radius);
    c1y = scale_round(table_sin(ang[seg_p1]), cur.radius);
    unique case (cur.mode)
      MODE_LINE: begin
        ax = px + nx;
        ay = py + ny;
        bx = half ? ex - nx : ex + nx;
        by = half ? ey - ny : ey + ny;
        cx = half ? px - nx : ex - nx;
        cy = half ? py - ny : ey - ny;
        cur_last = half;
      end
      MODE_CIRCLE: begin
        ax = px;
        ay = py;
        bx = px + 20'(c0x);
        by = py + 20'(c0y);
        cx = px + 20'(c1x);
        cy = py + 20'(c1y);
        cur_last = (seg == AW'(CIRCLE_SEGMENTS - 1));
      end
      default: begin
        ax = rx;
        ay = ry;
        bx = rx + rw;
        by = half ? ry + rh : ry;
        cx = half ? rx : rx + rw;
        cy = ry + rh;
        cur_last = half && ((cur.mode == MODE_RECT) || (higher == 4'd0));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {cur.color, sat16(cy), sat16(cx), sat16(by), sat16(bx),
                   sat16(ay), sat16(ax)};
      out_last <= cur_last;
    end
    if (pop) cur <= job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      half      <= 1'b0;
      ridx      <= '0;
      seg       <= '0;
    end else begin
      if (advance) out_valid <= active;
      if (fire && !cur_last) begin
        half <= !half;
        seg  <= seg_p1;
        if (half) ridx <= ridx_nxt;
      end
      if (pop) begin
        active <= 1'b1;
        half   <= 1'b0;
        seg    <= '0;
        ridx   <= ridx_first;
      end else if (fire && cur_last) begin
        active <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_keep_job: assert property (@(posedge clk) disable iff (rst)
    fire && !cur_last |=> active && out_valid)
    else $error("job dropped before its last triangle");
  a_edge_valid: assert property (@(posedge clk) disable iff (rst)
    active && (cur.mode == MODE_OUTLINE) && !half |-> cur.mask[ridx])
    else $error("empty outline edge selected");
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    active && (cur.mode == MODE_CIRCLE) |-> seg < AW'(CIRCLE_SEGMENTS))
    else $error("circle segment out of range");
`endif

endmodule
